>>> src/lcc_pkg.sv
// Shared constants and codes for the local clustering coefficient unit.
// No dependencies; compiled first.
`default_nettype none

package lcc_pkg;

    localparam int MAX_VERTICES    = 64;
    localparam int COEFF_FRAC_BITS = 16;

    localparam int MODE_W   = 2;
    localparam int VERT_W   = 6;
    localparam int VC_W     = 7;
    localparam int ROW_W    = 64;
    localparam int STATUS_W = 2;
    localparam int DEG_W    = 6;
    localparam int PAIR_W   = 11;
    localparam int COEF_W   = COEFF_FRAC_BITS + 1;

    localparam logic [VC_W-1:0] VC_RESET = VC_W'(64);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EDGE_REJ  = 2'd1,
        STATUS_QUERY_REJ = 2'd2,
        STATUS_SPARE     = 2'd3
    } status_t;

endpackage

`default_nettype wire

>>> src/lcc_if.sv
// Valid/ready channels of the clustering coefficient unit: command in, result out.
// Depends on lcc_pkg for field widths.
`default_nettype none

interface lcc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [lcc_pkg::MODE_W-1:0]    mode;
    logic [lcc_pkg::VERT_W-1:0]    vertex_a;
    logic [lcc_pkg::VERT_W-1:0]    vertex_b;

    modport source (output valid, mode, vertex_a, vertex_b, input ready);
    modport sink   (input valid, mode, vertex_a, vertex_b, output ready);
endinterface

interface lcc_res_if;
    logic                          valid;
    logic                          ready;
    logic [lcc_pkg::STATUS_W-1:0]  status;
    logic [lcc_pkg::DEG_W-1:0]     degree;
    logic [lcc_pkg::PAIR_W-1:0]    neighbour_pairs;
    logic [lcc_pkg::PAIR_W-1:0]    linked_pairs;
    logic [lcc_pkg::COEF_W-1:0]    coefficient;

    modport source (output valid, status, degree, neighbour_pairs, linked_pairs,
                    coefficient, input ready);
    modport sink   (input valid, status, degree, neighbour_pairs, linked_pairs,
                    coefficient, output ready);
endinterface

`default_nettype wire

>>> src/local_clustering_coefficient_unit.sv
// Local clustering coefficient unit: adjacency matrix in a 64x64 RAM, triangle count,
// restoring divider. Depends on lcc_pkg and the channels in lcc_if.
//
//   channel     dir   handshake              payload
//   cmd         in    cmd.valid/cmd.ready    mode, vertex_a, vertex_b
//   res         out   res.valid/res.ready    status, degree, neighbour_pairs,
//                                            linked_pairs, coefficient
//   cfg         in    cfg_we                 cfg_wdata (vertex_count)
//
// One item at a time. Add edge: two read-modify-writes of the RAM.
// Query: one RAM row read per cycle in the neighbour scan over the n active
// vertices, then 17 divider steps; no division when the degree is under 2.
// Clear, rejects and mode 3 go from idle straight to the finish state.
// Clear resets all per-row valid flags at once; reset leaves no clearing pass.
// A finished result sits in the output register; the next item is taken meanwhile,
// and the unit waits only if a new result is ready before the old one is taken.
`default_nettype none

module local_clustering_coefficient_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    lcc_cmd_if.sink                          cmd,
    lcc_res_if.source                        res,
    input  wire logic                        cfg_we,
    input  wire logic [lcc_pkg::VC_W-1:0]    cfg_wdata
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ADD_A  = 8'b0000_0010,
        ST_ADD_B  = 8'b0000_0100,
        ST_Q_ROW  = 8'b0000_1000,
        ST_Q_SCAN = 8'b0001_0000,
        ST_Q_PAIR = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    localparam int ROWS    = lcc_pkg::MAX_VERTICES;
    localparam int ROW_W   = lcc_pkg::ROW_W;
    localparam int VERT_W  = lcc_pkg::VERT_W;
    localparam int VC_W    = lcc_pkg::VC_W;
    localparam int DEG_W   = lcc_pkg::DEG_W;
    localparam int PAIR_W  = lcc_pkg::PAIR_W;
    localparam int COEF_W  = lcc_pkg::COEF_W;
    localparam int CNT_W   = $clog2(COEF_W);
    localparam int PC_W    = $clog2(ROW_W + 1);
    localparam int TWICE_W = PAIR_W + 1;
    localparam int REM_W   = PAIR_W + 1;

    function automatic logic [PC_W-1:0] popcnt(input logic [ROW_W-1:0] x);
        logic [PC_W-1:0] c;
        c = '0;
        for (int i = 0; i < ROW_W; i++)
        begin
            c = c + PC_W'(x[i]);
        end
        return c;
    endfunction

    // adjacency RAM, one row per vertex
    logic [ROW_W-1:0]    adj_mem [ROWS];
    logic [ROW_W-1:0]    rd_data_reg;
    logic                rd_valid_reg;
    logic [ROWS-1:0]     row_valid_reg, row_valid_next;
    logic [VERT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [VERT_W-1:0]   wr_addr;
    logic [ROW_W-1:0]    wr_data;
    logic [ROW_W-1:0]    row;

    state_t                      state_reg, state_next;
    logic [VC_W-1:0]             vc_reg, vc_next;
    logic [VC_W-1:0]             n_act;
    logic [ROW_W-1:0]            act_mask;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_load;

    logic [VERT_W-1:0]           a_reg, a_next;
    logic [VERT_W-1:0]           b_reg, b_next;
    logic [lcc_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ROW_W-1:0]            nb_reg, nb_next;
    logic [DEG_W-1:0]            deg_reg, deg_next;
    logic [VC_W-1:0]             scan_reg, scan_next;
    logic                        chk_reg, chk_next;
    logic [VERT_W-1:0]           chk_u_reg, chk_u_next;
    logic [TWICE_W-1:0]          twice_reg, twice_next;
    logic [PAIR_W-1:0]           pairs_reg, pairs_next;
    logic [PAIR_W-1:0]           linked_reg, linked_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [COEF_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    logic [lcc_pkg::STATUS_W-1:0] res_status_reg;
    logic [DEG_W-1:0]            res_deg_reg;
    logic [PAIR_W-1:0]           res_pairs_reg;
    logic [PAIR_W-1:0]           res_linked_reg;
    logic [COEF_W-1:0]           res_coef_reg;

    logic                        accept;
    logic [2*DEG_W-1:0]          pair_prod;
    logic [REM_W-1:0]            trial;
    logic                        trial_ge;
    logic [ROW_W-1:0]            nb_row;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || res.ready);

    assign n_act = (vc_reg > VC_W'(ROWS)) ? VC_W'(ROWS) : vc_reg;

    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            act_mask[i] = (VC_W'(i) < n_act);
        end
    end

    // a row never written since reset or clear reads as empty
    assign row = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            adj_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= adj_mem[rd_addr];
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   rd_addr = cmd.vertex_a;
            ST_ADD_A:  rd_addr = b_reg;
            ST_Q_SCAN: rd_addr = scan_reg[VERT_W-1:0];
            default:   rd_addr = a_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = a_reg;
        wr_data = row | (ROW_W'(1) << b_reg);
        if (state_reg == ST_ADD_A)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_ADD_B)
        begin
            wr_en   = 1'b1;
            wr_addr = b_reg;
            wr_data = row | (ROW_W'(1) << a_reg);
        end
    end

    assign pair_prod = (2*DEG_W)'(deg_reg) * (2*DEG_W)'(deg_reg - DEG_W'(1));
    assign trial     = (cnt_reg == CNT_W'(COEF_W - 1)) ? rem_reg : (rem_reg << 1);
    assign trial_ge  = (trial >= {1'b0, pairs_reg});
    assign nb_row    = row & nb_reg & ~(ROW_W'(1) << chk_u_reg);

    always_comb
    begin
        state_next     = state_reg;
        vc_next        = cfg_we ? cfg_wdata : vc_reg;
        row_valid_next = row_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        status_next    = status_reg;
        nb_next        = nb_reg;
        deg_next       = deg_reg;
        scan_next      = scan_reg;
        chk_next       = 1'b0;
        chk_u_next     = scan_reg[VERT_W-1:0];
        twice_next     = twice_reg;
        pairs_next     = pairs_reg;
        linked_next    = linked_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;

        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_next      = cmd.vertex_a;
                    b_next      = cmd.vertex_b;
                    status_next = lcc_pkg::STATUS_OK;
                    deg_next    = '0;
                    pairs_next  = '0;
                    linked_next = '0;
                    quo_next    = '0;
                    state_next  = ST_FINISH;
                    case (cmd.mode)
                        lcc_pkg::MODE_ADD:
                        begin
                            if (cmd.vertex_a == cmd.vertex_b
                                || VC_W'(cmd.vertex_a) >= n_act
                                || VC_W'(cmd.vertex_b) >= n_act)
                            begin
                                status_next = lcc_pkg::STATUS_EDGE_REJ;
                            end
                            else
                            begin
                                state_next = ST_ADD_A;
                            end
                        end
                        lcc_pkg::MODE_QUERY:
                        begin
                            if (VC_W'(cmd.vertex_a) >= n_act)
                            begin
                                status_next = lcc_pkg::STATUS_QUERY_REJ;
                            end
                            else
                            begin
                                state_next = ST_Q_ROW;
                            end
                        end
                        lcc_pkg::MODE_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD_A:
            begin
                state_next = ST_ADD_B;
            end
            ST_ADD_B:
            begin
                state_next = ST_FINISH;
            end
            ST_Q_ROW:
            begin
                nb_next    = row & act_mask & ~(ROW_W'(1) << a_reg);
                deg_next   = DEG_W'(popcnt(nb_next));
                scan_next  = '0;
                twice_next = '0;
                state_next = ST_Q_SCAN;
            end
            ST_Q_SCAN:
            begin
                // read row u now, count its neighbours among nb when it returns
                if (scan_reg < n_act)
                begin
                    chk_next  = 1'b1;
                    scan_next = scan_reg + VC_W'(1);
                end
                if (chk_reg && nb_reg[chk_u_reg])
                begin
                    twice_next = twice_reg + TWICE_W'(popcnt(nb_row));
                end
                if (scan_reg >= n_act && !chk_reg)
                begin
                    state_next = ST_Q_PAIR;
                end
            end
            ST_Q_PAIR:
            begin
                pairs_next  = PAIR_W'(pair_prod >> 1);
                linked_next = twice_reg[TWICE_W-1:1];
                rem_next    = {1'b0, twice_reg[TWICE_W-1:1]};
                quo_next    = '0;
                cnt_next    = CNT_W'(COEF_W - 1);
                state_next  = (deg_reg < DEG_W'(2)) ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? (trial - {1'b0, pairs_reg}) : trial;
                quo_next = {quo_reg[COEF_W-2:0], trial_ge};
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vc_reg        <= lcc_pkg::VC_RESET;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chk_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= row_valid_reg[rd_addr];
            out_valid_reg <= out_valid_next;
            chk_reg       <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        status_reg <= status_next;
        nb_reg     <= nb_next;
        deg_reg    <= deg_next;
        scan_reg   <= scan_next;
        chk_u_reg  <= chk_u_next;
        twice_reg  <= twice_next;
        pairs_reg  <= pairs_next;
        linked_reg <= linked_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        if (out_load)
        begin
            res_status_reg <= status_reg;
            res_deg_reg    <= deg_reg;
            res_pairs_reg  <= pairs_reg;
            res_linked_reg <= linked_reg;
            res_coef_reg   <= quo_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.status          = res_status_reg;
    assign res.degree          = res_deg_reg;
    assign res.neighbour_pairs = res_pairs_reg;
    assign res.linked_pairs    = res_linked_reg;
    assign res.coefficient     = res_coef_reg;

`ifndef SYNTH
    a_clear_drops_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.mode == lcc_pkg::MODE_CLEAR) |=> (row_valid_reg == '0))
        else $error("clear left rows marked valid");

    a_linked_le_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.linked_pairs <= res.neighbour_pairs))
        else $error("linked pairs exceed neighbour pairs");

    a_coef_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.coefficient <= (COEF_W'(1) << (COEF_W - 1))))
        else $error("coefficient above one");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != CNT_W'(COEF_W - 1))
            |-> (rem_reg < {1'b0, pairs_reg}))
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

>>> bench/local_clustering_coefficient_unit_tb.sv
// Testbench for local_clustering_coefficient_unit: edge adds, vertex queries and clears
// checked against an in-bench graph predictor. Depends on lcc_pkg and lcc_if.
`default_nettype none

module local_clustering_coefficient_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DEG_W-1:0]    degree;
        logic [PAIR_W-1:0]   pairs;
        logic [PAIR_W-1:0]   linked;
        logic [COEF_W-1:0]   coef;
    } lcc_result_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [VC_W-1:0] cfg_wdata;

    lcc_cmd_if cmd_ch ();
    lcc_res_if res_ch ();

    local_clustering_coefficient_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // graph predictor state
    logic [ROW_W-1:0] adj_rows [MAX_VERTICES];
    logic [VC_W-1:0]  vertex_count_q;
    lcc_result_t      pending_results [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int result_num  = 0;

    // sender and receiver pacing
    bit gaps_on    = 1'b1;
    int burst_left = 0;
    int recv_style = 1;
    int hold_req   = 0;
    int hold_left  = 0;

    function automatic lcc_result_t apply_command(mode_t m, logic [VERT_W-1:0] va,
                                                  logic [VERT_W-1:0] vb);
        lcc_result_t      r;
        int               n;
        int               deg;
        int               pairs;
        int               twice;
        longint           coef;
        logic [ROW_W-1:0] mask;
        logic [ROW_W-1:0] nbrs;
        logic [ROW_W-1:0] common;
        r     = '0;
        n     = (vertex_count_q > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_q);
        twice = 0;
        coef  = 0;
        case (m)
            MODE_ADD:
            begin
                if (va == vb || va >= n || vb >= n)
                begin
                    r.status = STATUS_EDGE_REJ;
                end
                else
                begin
                    adj_rows[va][vb] = 1'b1;
                    adj_rows[vb][va] = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                if (va >= n)
                begin
                    r.status = STATUS_QUERY_REJ;
                end
                else
                begin
                    mask     = (n >= ROW_W) ? '1 : (64'd1 << n) - 64'd1;
                    nbrs     = adj_rows[va] & mask;
                    nbrs[va] = 1'b0;
                    deg      = $countones(nbrs);
                    pairs    = deg * (deg - 1) / 2;
                    for (int u = 0; u < n; u++)
                    begin
                        if (nbrs[u])
                        begin
                            common    = adj_rows[u] & nbrs;
                            common[u] = 1'b0;
                            twice    += $countones(common);
                        end
                    end
                    // every linked pair is counted from both ends
                    twice = twice / 2;
                    if (deg >= 2)
                        coef = (longint'(twice) << COEFF_FRAC_BITS) / pairs;
                    r.degree = DEG_W'(deg);
                    r.pairs  = PAIR_W'(pairs);
                    r.linked = PAIR_W'(twice);
                    r.coef   = COEF_W'(coef);
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < MAX_VERTICES; i++)
                    adj_rows[i] = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [COEF_W-1:0] exp_v,
                               logic [COEF_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
                     $time, result_num, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // config tracking, result checking and command prediction, in that order
    always @(posedge clk)
    begin
        lcc_result_t exp_r;
        if (rst_n)
        begin
            if (cfg_we)
                vertex_count_q = cfg_wdata;
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result %0d arrived with nothing expected", $time,
                             result_num);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("status", exp_r.status, res_ch.status);
                    check_field("degree", exp_r.degree, res_ch.degree);
                    check_field("neighbour_pairs", exp_r.pairs, res_ch.neighbour_pairs);
                    check_field("linked_pairs", exp_r.linked, res_ch.linked_pairs);
                    check_field("coefficient", exp_r.coef, res_ch.coefficient);
                end
                result_num++;
            end
            if (cmd_ch.valid && cmd_ch.ready)
                pending_results.push_back(apply_command(mode_t'(cmd_ch.mode),
                                                        cmd_ch.vertex_a, cmd_ch.vertex_b));
        end
    end

    // result side: random on/off stretches, plus a long hold-off on request
    initial
    begin
        int on_left;
        int off_left;
        on_left      = 0;
        off_left     = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (recv_style == 0)
            begin
                res_ch.ready <= 1'b1;
            end
            else
            begin
                if (on_left == 0 && off_left == 0)
                begin
                    on_left  = $urandom_range(1, 12);
                    off_left = (recv_style == 2) ? $urandom_range(1, 8) : $urandom_range(0, 3);
                end
                if (on_left > 0)
                begin
                    on_left--;
                    res_ch.ready <= 1'b1;
                end
                else
                begin
                    off_left--;
                    res_ch.ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("local_clustering_coefficient_unit test failed");
        $finish;
    end

    task automatic send_item(mode_t m, logic [VERT_W-1:0] va, logic [VERT_W-1:0] vb);
        if (gaps_on && burst_left == 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= m;
        cmd_ch.vertex_a <= va;
        cmd_ch.vertex_b <= vb;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // sender stops until every outstanding item has come back
    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_vertex_count(logic [VC_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_basic_graph();
        write_vertex_count(VC_W'(64));
        send_item(MODE_ADD, 6'd0, 6'd63);
        send_item(MODE_ADD, 6'd63, 6'd0);       // duplicate, reversed
        send_item(MODE_ADD, 6'd5, 6'd5);        // self loop
        send_item(MODE_ADD, 6'd1, 6'd63);
        send_item(MODE_ADD, 6'd0, 6'd1);
        send_item(MODE_QUERY, 6'd0, 6'd42);     // full triangle
        send_item(MODE_ADD, 6'd2, 6'd0);
        send_item(MODE_QUERY, 6'd0, 6'd0);
        send_item(MODE_QUERY, 6'd5, 6'd63);     // isolated vertex
        send_item(MODE_NONE, 6'd63, 6'd63);
        send_item(MODE_CLEAR, 6'd63, 6'd63);
        send_item(MODE_QUERY, 6'd0, 6'd0);
    endtask

    task automatic test_vertex_range();
        write_vertex_count(VC_W'(4));
        send_item(MODE_ADD, 6'd3, 6'd4);
        send_item(MODE_ADD, 6'd0, 6'd3);
        send_item(MODE_ADD, 6'd1, 6'd3);
        send_item(MODE_ADD, 6'd0, 6'd1);
        send_item(MODE_QUERY, 6'd3, 6'd0);
        send_item(MODE_QUERY, 6'd4, 6'd0);
        // shrink: edges to vertex 3 stay stored but are hidden
        write_vertex_count(VC_W'(2));
        send_item(MODE_QUERY, 6'd0, 6'd0);
        write_vertex_count(VC_W'(0));
        send_item(MODE_QUERY, 6'd0, 6'd0);
        send_item(MODE_ADD, 6'd0, 6'd1);
        write_vertex_count(VC_W'(127));
        send_item(MODE_ADD, 6'd62, 6'd63);
        send_item(MODE_QUERY, 6'd63, 6'd0);
        write_vertex_count(VC_W'(1));
        send_item(MODE_QUERY, 6'd0, 6'd0);
    endtask

    // vertex 63 joined to every other vertex: largest degree and pair count
    task automatic test_hub_vertex();
        write_vertex_count(VC_W'(64));
        send_item(MODE_CLEAR, 6'd0, 6'd0);
        for (int k = 0; k < 63; k++)
            send_item(MODE_ADD, 6'd63, VERT_W'(k));
        for (int k = 0; k < 16; k += 2)
            send_item(MODE_ADD, VERT_W'(k), VERT_W'(k + 1));
        send_item(MODE_QUERY, 6'd63, 6'd0);
        send_item(MODE_QUERY, 6'd0, 6'd0);
        send_item(MODE_QUERY, 6'd40, 6'd0);
        write_vertex_count(VC_W'(65));
        send_item(MODE_QUERY, 6'd63, 6'd0);
    endtask

    // output held off while the sender keeps pushing; input must stall
    task automatic test_output_hold();
        drain_results();
        gaps_on = 1'b0;
        hold_req = 400;
        for (int k = 0; k < 40; k++)
            send_item(mode_t'($urandom_range(0, 1)), VERT_W'($urandom_range(0, 63)),
                      VERT_W'($urandom_range(0, 63)));
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic random_item(int n_eff, int base, int span);
        int          pick;
        logic [VERT_W-1:0] va;
        logic [VERT_W-1:0] vb;
        pick = $urandom_range(0, 99);
        if (n_eff < 2 || pick >= 90)
        begin
            send_item(mode_t'($urandom_range(0, 3)), VERT_W'($urandom_range(0, 63)),
                      VERT_W'($urandom_range(0, 63)));
        end
        else
        begin
            // half of the traffic stays in a small cluster so triangles build up
            if ($urandom_range(0, 1) != 0)
            begin
                va = VERT_W'(base + $urandom_range(0, span - 1));
                vb = VERT_W'(base + $urandom_range(0, span - 1));
            end
            else
            begin
                va = VERT_W'($urandom_range(0, n_eff - 1));
                vb = VERT_W'($urandom_range(0, n_eff - 1));
            end
            if (pick < 52)
                send_item(MODE_ADD, va, vb);
            else if (pick < 89)
                send_item(MODE_QUERY, va, VERT_W'($urandom_range(0, 63)));
            else
                send_item(MODE_CLEAR, va, vb);
        end
    endtask

    task automatic test_random_phases(int phases, int per_phase);
        int vc;
        int n_eff;
        int span;
        int base;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(0, 7))
                0: vc = $urandom_range(2, 8);
                1: vc = $urandom_range(9, 63);
                2: vc = $urandom_range(65, 127);
                3: vc = (p % 2 == 0) ? 0 : 1;
                default: vc = 64;
            endcase
            write_vertex_count(VC_W'(vc));
            n_eff      = (vc > 64) ? 64 : vc;
            span       = (n_eff < 8) ? ((n_eff < 1) ? 1 : n_eff) : 8;
            base       = (n_eff > span) ? $urandom_range(0, n_eff - span) : 0;
            gaps_on    = ($urandom_range(0, 3) != 0);
            recv_style = $urandom_range(0, 2);
            if ($urandom_range(0, 1) != 0)
                send_item(MODE_CLEAR, 6'd0, 6'd0);
            for (int i = 0; i < per_phase; i++)
                random_item(n_eff, base, span);
        end
        gaps_on    = 1'b1;
        recv_style = 1;
    endtask

    initial
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
            adj_rows[i] = '0;
        vertex_count_q  = VC_RESET;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = VC_RESET;
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_ADD;
        cmd_ch.vertex_a = '0;
        cmd_ch.vertex_b = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_basic_graph();
        test_vertex_range();
        test_hub_vertex();
        test_output_hold();
        test_random_phases(10, 120);

        drain_results();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("local_clustering_coefficient_unit test passed");
        end
        else
        begin
            $display("local_clustering_coefficient_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
